// File: design/tpc_pkg.sv
// tpc_pkg: shared types and constants for the triangle plane clipper.
// Used by tpc_front, tpc_queue, tpc_back and triangle_plane_clipper.
package tpc_pkg;

  localparam int unsigned CW  = 32;        // coordinate width
  localparam int unsigned NW  = 18;        // normal component width
  localparam int unsigned PRW = 50;        // normal * coordinate product
  localparam int unsigned DW  = 53;        // signed plane distance
  localparam int unsigned RW  = 55;        // divider remainder / divisor
  localparam int unsigned TRI_W = 9 * CW;  // one packed triangle

  localparam logic [2:0] REG_POINT_X  = 3'd0;
  localparam logic [2:0] REG_POINT_Y  = 3'd1;
  localparam logic [2:0] REG_POINT_Z  = 3'd2;
  localparam logic [2:0] REG_NORMAL_X = 3'd3;
  localparam logic [2:0] REG_NORMAL_Y = 3'd4;
  localparam logic [2:0] REG_NORMAL_Z = 3'd5;

  typedef logic [2:0][CW-1:0] vtx_t;

  typedef enum logic [1:0] {
    KIND_NONE,   // all outside, dropped
    KIND_PASS,   // all inside, unchanged
    KIND_ONE,    // one inside, one shrunken triangle
    KIND_TWO     // two inside, two triangles
  } kind_t;

  typedef struct packed {
    logic [2:0][CW-1:0] pt;
    logic [2:0][NW-1:0] nrm;
  } plane_t;

  // vx/dd hold the vertices reordered: inside ones first, each group in input order
  typedef struct packed {
    kind_t              kind;
    vtx_t [2:0]         vx;
    logic [2:0][DW-1:0] dd;
  } qitem_t;

endpackage

// File: design/tpc_front.sv
// tpc_front: distance pipeline and inside/outside classification.
// Depends on tpc_pkg.
module tpc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [tpc_pkg::TRI_W-1:0] in_data,
  input  tpc_pkg::plane_t          plane,
  output logic                     push,
  output tpc_pkg::qitem_t          item,
  input  logic                     full
);

  logic                           f1_valid, f2_valid, fe, want;
  logic signed [tpc_pkg::PRW-1:0] f1_prod [3][3];
  logic signed [tpc_pkg::PRW-1:0] f1_np [3];
  tpc_pkg::vtx_t                  f1_v [3];
  tpc_pkg::vtx_t                  f2_v [3];
  logic signed [tpc_pkg::DW-1:0]  f2_d [3];
  logic signed [tpc_pkg::DW-1:0]  d_c [3];
  tpc_pkg::vtx_t                  vin [3];
  logic [2:0]                     mask;
  logic [1:0]                     ord [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        vin[i][j] = in_data[(i*3+j)*tpc_pkg::CW +: tpc_pkg::CW];
  end

  // stall only when the queue cannot take a triangle that produces output
  assign want     = f2_valid && (item.kind != tpc_pkg::KIND_NONE);
  assign fe       = !(want && full);
  assign in_ready = fe;
  assign push     = want && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (fe) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++)
      d_c[i] = tpc_pkg::DW'(f1_prod[i][0]) + tpc_pkg::DW'(f1_prod[i][1])
             + tpc_pkg::DW'(f1_prod[i][2]) - tpc_pkg::DW'(f1_np[0])
             - tpc_pkg::DW'(f1_np[1]) - tpc_pkg::DW'(f1_np[2]);
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++)
          f1_prod[i][j] <= $signed(plane.nrm[j]) * $signed(vin[i][j]);
        f1_np[i] <= $signed(plane.nrm[i]) * $signed(plane.pt[i]);
        f1_v[i]  <= vin[i];
        f2_v[i]  <= f1_v[i];
        f2_d[i]  <= d_c[i];
      end
    end
  end

  // classification; inside means distance >= 0
  always_comb begin
    for (int i = 0; i < 3; i++)
      mask[i] = !f2_d[i][tpc_pkg::DW-1];
    ord[0] = 2'd0; ord[1] = 2'd1; ord[2] = 2'd2;
    item.kind = tpc_pkg::KIND_NONE;
    unique case (mask)
      3'b000: item.kind = tpc_pkg::KIND_NONE;
      3'b111: item.kind = tpc_pkg::KIND_PASS;
      3'b001: item.kind = tpc_pkg::KIND_ONE;
      3'b010: begin item.kind = tpc_pkg::KIND_ONE; ord[0] = 2'd1; ord[1] = 2'd0; end
      3'b100: begin
        item.kind = tpc_pkg::KIND_ONE; ord[0] = 2'd2; ord[1] = 2'd0; ord[2] = 2'd1;
      end
      3'b011: item.kind = tpc_pkg::KIND_TWO;
      3'b101: begin item.kind = tpc_pkg::KIND_TWO; ord[1] = 2'd2; ord[2] = 2'd1; end
      3'b110: begin
        item.kind = tpc_pkg::KIND_TWO; ord[0] = 2'd1; ord[1] = 2'd2; ord[2] = 2'd0;
      end
      default: item.kind = tpc_pkg::KIND_NONE;
    endcase
    for (int k = 0; k < 3; k++) begin
      item.vx[k] = f2_v[ord[k]];
      item.dd[k] = f2_d[ord[k]];
    end
  end

endmodule

// File: design/tpc_queue.sv
// tpc_queue: short FIFO with a registered head between front and back.
// Depends on tpc_pkg.
module tpc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tpc_pkg::qitem_t wdata,
  output logic            full,
  input  logic            rd,
  output logic            ovalid,
  output tpc_pkg::qitem_t odata
);

  tpc_pkg::qitem_t mem [4];
  logic [1:0]      wptr, rptr;
  logic [2:0]      cnt;
  logic            load_out, from_mem, bypass, wr_mem;

  assign full     = (cnt == 3'd4);
  assign load_out = !ovalid || rd;
  assign from_mem = load_out && (cnt != 3'd0);
  assign bypass   = load_out && (cnt == 3'd0) && push;
  assign wr_mem   = push && !bypass;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      cnt    <= '0;
      ovalid <= 1'b0;
    end else begin
      if (wr_mem) wptr <= wptr + 2'd1;
      if (from_mem) rptr <= rptr + 2'd1;
      cnt <= cnt + {2'b0, wr_mem} - {2'b0, from_mem};
      if (load_out) ovalid <= from_mem || bypass;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_mem) mem[wptr] <= wdata;
    if (from_mem) odata <= mem[rptr];
    else if (bypass) odata <= wdata;
  end

endmodule

// File: design/tpc_back.sv
// tpc_back: edge-point pipeline (restoring divider, multiply, saturate) and
// the result emitter. Depends on tpc_pkg.
module tpc_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  tpc_pkg::qitem_t           q_data,
  output logic                      q_rd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tpc_pkg::TRI_W-1:0] out_data,
  output logic                      out_last
);

  localparam int unsigned PW = tpc_pkg::CW + 2 + FRAC_BITS;
  localparam int unsigned SW = tpc_pkg::CW + 3;
  localparam int unsigned RW = tpc_pkg::RW;

  logic                 adv, e_take, e_last_now;

  // divider stages: stage k holds the state after k steps
  logic                 dval [FRAC_BITS+1];
  tpc_pkg::kind_t       dkind [FRAC_BITS+1];
  tpc_pkg::vtx_t [2:0]  dvx [FRAC_BITS+1];
  logic [RW-1:0]        dr [FRAC_BITS+1][2];
  logic [RW-1:0]        dden [FRAC_BITS+1][2];
  logic [FRAC_BITS-1:0] dt [FRAC_BITS+1][2];
  logic [RW-1:0]        r2 [FRAC_BITS][2];
  logic signed [tpc_pkg::DW:0] da [2], db [2];

  logic                 mval;
  tpc_pkg::kind_t       mkind;
  tpc_pkg::vtx_t [2:0]  mvx;
  logic signed [PW-1:0] mprod [2][3];
  logic signed [tpc_pkg::CW:0] delta [2][3];
  tpc_pkg::vtx_t        la [2], lb [2], ma [2];

  logic                 sval;
  tpc_pkg::kind_t       skind;
  tpc_pkg::vtx_t [2:0]  svx;
  tpc_pkg::vtx_t        sx [2];
  tpc_pkg::vtx_t        sx_c [2];
  logic signed [PW-1:0] sh;
  logic signed [SW-1:0] ssum;

  logic                 e_valid, e_phase;
  tpc_pkg::kind_t       e_kind;
  tpc_pkg::vtx_t [2:0]  evx;
  tpc_pkg::vtx_t        ex [2];
  tpc_pkg::vtx_t        t0, t1, t2;

  assign e_last_now = (e_kind != tpc_pkg::KIND_TWO) || e_phase;
  assign e_take     = !e_valid || (out_ready && e_last_now);
  assign adv        = e_take;
  assign q_rd       = adv;

  // lane 0: (vx0, vx1) for one inside, else (vx0, vx2); lane 1: (vx0|vx1, vx2)
  always_comb begin
    da[0] = (tpc_pkg::DW+1)'($signed(q_data.dd[0]));
    db[0] = (tpc_pkg::DW+1)'($signed((q_data.kind == tpc_pkg::KIND_ONE) ?
                                     q_data.dd[1] : q_data.dd[2]));
    da[1] = (tpc_pkg::DW+1)'($signed((q_data.kind == tpc_pkg::KIND_ONE) ?
                                     q_data.dd[0] : q_data.dd[1]));
    db[1] = (tpc_pkg::DW+1)'($signed(q_data.dd[2]));
  end

  always_comb begin
    for (int k = 0; k < FRAC_BITS; k++)
      for (int l = 0; l < 2; l++)
        r2[k][l] = {dr[k][l][RW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= FRAC_BITS; k++) dval[k] <= 1'b0;
      mval <= 1'b0;
      sval <= 1'b0;
    end else if (adv) begin
      dval[0] <= q_valid;
      for (int k = 0; k < FRAC_BITS; k++) dval[k+1] <= dval[k];
      mval <= dval[FRAC_BITS];
      sval <= mval;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dkind[0] <= q_data.kind;
      dvx[0]   <= q_data.vx;
      for (int l = 0; l < 2; l++) begin
        dr[0][l]   <= RW'(da[l]);
        dden[0][l] <= RW'(da[l] - db[l]);
        dt[0][l]   <= '0;
      end
      for (int k = 0; k < FRAC_BITS; k++) begin
        dkind[k+1] <= dkind[k];
        dvx[k+1]   <= dvx[k];
        for (int l = 0; l < 2; l++) begin
          dden[k+1][l] <= dden[k][l];
          if (r2[k][l] >= dden[k][l]) begin
            dr[k+1][l] <= r2[k][l] - dden[k][l];
            dt[k+1][l] <= {dt[k][l][FRAC_BITS-2:0], 1'b1};
          end else begin
            dr[k+1][l] <= r2[k][l];
            dt[k+1][l] <= {dt[k][l][FRAC_BITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  // multiply stage: (b - a) * t per lane and coordinate
  always_comb begin
    la[0] = dvx[FRAC_BITS][0];
    lb[0] = (dkind[FRAC_BITS] == tpc_pkg::KIND_ONE) ? dvx[FRAC_BITS][1] : dvx[FRAC_BITS][2];
    la[1] = (dkind[FRAC_BITS] == tpc_pkg::KIND_ONE) ? dvx[FRAC_BITS][0] : dvx[FRAC_BITS][1];
    lb[1] = dvx[FRAC_BITS][2];
    for (int l = 0; l < 2; l++)
      for (int j = 0; j < 3; j++)
        delta[l][j] = (tpc_pkg::CW+1)'($signed(lb[l][j]))
                    - (tpc_pkg::CW+1)'($signed(la[l][j]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mkind <= dkind[FRAC_BITS];
      mvx   <= dvx[FRAC_BITS];
      for (int l = 0; l < 2; l++) begin
        ma[l] <= la[l];
        for (int j = 0; j < 3; j++)
          mprod[l][j] <= delta[l][j] * $signed({1'b0, dt[FRAC_BITS][l]});
      end
    end
  end

  // add stage: a + floor(prod / 2^FRAC_BITS), saturated to 32 bits
  always_comb begin
    sh   = '0;
    ssum = '0;
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < 3; j++) begin
        sh   = mprod[l][j] >>> FRAC_BITS;
        ssum = SW'($signed(ma[l][j])) + SW'(sh);
        if (ssum > SW'(32'sh7fffffff)) sx_c[l][j] = 32'h7fffffff;
        else if (ssum < SW'(-33'sh80000000)) sx_c[l][j] = 32'h80000000;
        else sx_c[l][j] = ssum[tpc_pkg::CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      skind <= mkind;
      svx   <= mvx;
      sx    <= sx_c;
    end
  end

  // emitter: one or two triangles per item
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_phase <= 1'b0;
    end else if (adv) begin
      e_valid <= sval;
      e_phase <= 1'b0;
    end else if (e_valid && out_ready) begin
      e_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_kind <= skind;
      evx    <= svx;
      ex     <= sx;
    end
  end

  always_comb begin
    t0 = evx[0];
    t1 = evx[1];
    t2 = evx[2];
    unique case (e_kind)
      tpc_pkg::KIND_ONE: begin t1 = ex[0]; t2 = ex[1]; end
      tpc_pkg::KIND_TWO: begin
        if (e_phase) begin t0 = evx[1]; t1 = ex[0]; t2 = ex[1]; end
        else t2 = ex[0];
      end
      default: t0 = evx[0];
    endcase
  end

  assign out_valid = e_valid;
  assign out_data  = {t2, t1, t0};
  assign out_last  = e_last_now;

endmodule

// File: design/triangle_plane_clipper.sv
// triangle_plane_clipper: top level; config registers and the three stages.
// Depends on tpc_pkg, tpc_front, tpc_queue, tpc_back.
//
// Usage:
//  s_axis: one word = one triangle, three xyz vertices, signed Q16.16.
//  m_axis: zero, one or two triangles per input word; tlast marks the
//    final triangle of one input. A triangle fully outside gives no word.
//  cfg: plane point (index 0..2) and inside-pointing normal (3..5),
//    written while the block is idle; unknown indexes are ignored.
// Path from input to first result: two distance stages, queue head,
//  FRAC_BITS+1 divider stages, multiply, add/saturate, output register.
// Throughput: one input per cycle while each gives at most one triangle and m_axis
//  is not stalled; a two-triangle input holds the back pipeline until both of its
//  triangles are taken. Both edge divisions run in parallel fully pipelined lanes.
// Reset clears all valid bits and loads the default plane (z >= 0.1).
// Output stall freezes the back pipeline; the four-entry queue lets the
//  front keep taking words until it fills, then s_axis_tready drops.
module triangle_plane_clipper #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // v0.x, v0.y, v0.z, v1.x, v1.y, v1.z, v2.x, v2.y, v2.z (32 bits each)
  input  logic [tpc_pkg::TRI_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // out v0.x .. out v2.z, same order and widths as the input word
  output logic [tpc_pkg::TRI_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data
);

  tpc_pkg::plane_t plane;
  tpc_pkg::qitem_t q_wdata, q_odata;
  logic            q_push, q_full, q_rd, q_valid;

  // plane registers; reset point (0, 0, 0.1), normal (0, 0, 1.0)
  always_ff @(posedge clk) begin
    if (rst) begin
      plane.pt[0]  <= '0;
      plane.pt[1]  <= '0;
      plane.pt[2]  <= 32'd6554;
      plane.nrm[0] <= '0;
      plane.nrm[1] <= '0;
      plane.nrm[2] <= 18'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpc_pkg::REG_POINT_X:  plane.pt[0]  <= cfg_data;
        tpc_pkg::REG_POINT_Y:  plane.pt[1]  <= cfg_data;
        tpc_pkg::REG_POINT_Z:  plane.pt[2]  <= cfg_data;
        tpc_pkg::REG_NORMAL_X: plane.nrm[0] <= cfg_data[tpc_pkg::NW-1:0];
        tpc_pkg::REG_NORMAL_Y: plane.nrm[1] <= cfg_data[tpc_pkg::NW-1:0];
        tpc_pkg::REG_NORMAL_Z: plane.nrm[2] <= cfg_data[tpc_pkg::NW-1:0];
        default: ;
      endcase
    end
  end

  tpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .plane    (plane),
    .push     (q_push),
    .item     (q_wdata),
    .full     (q_full)
  );

  tpc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .rd     (q_rd),
    .ovalid (q_valid),
    .odata  (q_odata)
  );

  tpc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_odata),
    .q_rd      (q_rd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  // queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue overflow");

  // the second triangle of a pair is ready right after the first is taken
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("second triangle of pair missing");

  // nothing leaves the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("output valid after reset");
`endif

endmodule
